// ----- rtl/core/spq_pkg.sv -----
// Shared types and constants for the sorted priority queue.
// No dependencies; every other file of the block imports this package.
package spq_pkg;

    localparam int SPQ_DEPTH  = 128;
    localparam int DATA_W     = 32;
    localparam int PRIO_W     = 16;

    typedef enum logic {
        REQ_ENQ = 1'b0,
        REQ_DEQ = 1'b1
    } spq_req_type_t;

    typedef enum logic [1:0] {
        ST_ENQUEUED = 2'd0,
        ST_FULL     = 2'd1,
        ST_DEQUEUED = 2'd2,
        ST_EMPTY    = 2'd3
    } spq_status_t;

    typedef struct packed {
        logic [PRIO_W-1:0]        prio;
        logic signed [DATA_W-1:0] data;
    } spq_entry_t;

    typedef struct packed {
        logic       enq;
        logic       deq;
        spq_entry_t item;
    } spq_cmd_t;

endpackage

// ----- rtl/core/spq_req_if.sv -----
// Request channel of the sorted priority queue: valid, ready and payload.
// Depends on spq_pkg.
interface spq_req_if;
    import spq_pkg::*;

    logic                     valid;
    logic                     ready;
    spq_req_type_t            req_type;
    logic signed [DATA_W-1:0] data;
    logic [PRIO_W-1:0]        priority_req;

    modport source (output valid, output req_type, output data, output priority_req,
                    input ready);
    modport sink   (input valid, input req_type, input data, input priority_req,
                    output ready);
endinterface

// ----- rtl/core/spq_rsp_if.sv -----
// Response channel of the sorted priority queue: valid, ready and payload.
// Depends on spq_pkg.
interface spq_rsp_if;
    import spq_pkg::*;

    logic                     valid;
    logic                     ready;
    spq_status_t              status;
    logic signed [DATA_W-1:0] out_data;
    logic [PRIO_W-1:0]        out_priority;

    modport source (output valid, output status, output out_data, output out_priority,
                    input ready);
    modport sink   (input valid, input status, input out_data, input out_priority,
                    output ready);
endinterface

// ----- rtl/core/spq_cell.sv -----
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
// Depends on spq_pkg.
module spq_cell (
    input  logic               clk,
    input  spq_pkg::spq_cmd_t  cmd,
    input  logic               occupied,
    input  spq_pkg::spq_entry_t left_entry,
    input  logic               left_keep,
    input  spq_pkg::spq_entry_t right_entry,
    output spq_pkg::spq_entry_t entry,
    output logic               keep
);
    import spq_pkg::*;

    spq_entry_t entry_reg;
    spq_entry_t entry_next;

    // An entry stays ahead of a new one when its priority is not lower.
    assign keep  = occupied && (entry_reg.prio >= cmd.item.prio);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.enq)
        begin
            if (!keep)
            begin
                entry_next = left_keep ? cmd.item : left_entry;
            end
        end
        else if (cmd.deq)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ----- rtl/core/sorted_priority_queue.sv -----
// Sorted priority queue built as a chain of cells, head entry in cell 0.
// The response is registered and valid in the cycle after the request transfer;
// one request per cycle unless the response stalls, as every cell updates in the
// same cycle from its own entry and neighbors. Reset clears the entry count and
// the response valid flag; cell contents stay undefined, never read before written.
// Depends on spq_pkg, spq_req_if, spq_rsp_if and spq_cell.
module sorted_priority_queue #(
    parameter int DEPTH = spq_pkg::SPQ_DEPTH
) (
    input  logic      clk,
    input  logic      rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);
    import spq_pkg::*;

    localparam int CntW = $clog2(DEPTH + 1);

    logic [CntW-1:0]          count_reg;
    logic [CntW-1:0]          count_next;
    logic                     rsp_valid_reg;
    logic                     rsp_valid_next;
    spq_status_t              status_reg;
    spq_status_t              status_next;
    logic signed [DATA_W-1:0] out_data_reg;
    logic signed [DATA_W-1:0] out_data_next;
    logic [PRIO_W-1:0]        out_prio_reg;
    logic [PRIO_W-1:0]        out_prio_next;

    logic       accept;
    logic       full;
    logic       empty;
    spq_cmd_t   cmd;
    spq_entry_t cell_entry [DEPTH];
    logic       cell_keep  [DEPTH];

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign full      = (count_reg == CntW'(DEPTH));
    assign empty     = (count_reg == '0);

    assign cmd.enq       = accept && (req.req_type == REQ_ENQ) && !full;
    assign cmd.deq       = accept && (req.req_type == REQ_DEQ) && !empty;
    assign cmd.item.prio = req.priority_req;
    assign cmd.item.data = req.data;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        spq_entry_t left_e;
        logic       left_k;
        spq_entry_t right_e;

        if (i == 0)
        begin : g_head
            assign left_e = cmd.item;
            assign left_k = 1'b1;
        end
        else
        begin : g_body
            assign left_e = cell_entry[i-1];
            assign left_k = cell_keep[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_e = cell_entry[i];
        end
        else
        begin : g_mid
            assign right_e = cell_entry[i+1];
        end

        spq_cell u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .occupied   (CntW'(i) < count_reg),
            .left_entry (left_e),
            .left_keep  (left_k),
            .right_entry(right_e),
            .entry      (cell_entry[i]),
            .keep       (cell_keep[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.enq)
        begin
            count_next = count_reg + CntW'(1);
        end
        else if (cmd.deq)
        begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        status_next    = status_reg;
        out_data_next  = out_data_reg;
        out_prio_next  = out_prio_reg;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
            out_data_next  = '0;
            out_prio_next  = '0;
            unique case (req.req_type)
                REQ_ENQ:
                begin
                    status_next = full ? ST_FULL : ST_ENQUEUED;
                end
                REQ_DEQ:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        status_next   = ST_DEQUEUED;
                        out_data_next = cell_entry[0].data;
                        out_prio_next = cell_entry[0].prio;
                    end
                end
                default:
                begin
                    status_next = ST_EMPTY;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
        out_prio_reg <= out_prio_next;
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.out_data     = out_data_reg;
    assign rsp.out_priority = out_prio_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(DEPTH))
        else $error("entry count exceeds depth");

    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp.valid)
        else $error("no response after request transfer");

    a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.req_type == REQ_ENQ && full) |=>
        (rsp.status == ST_FULL && count_reg == CntW'(DEPTH)))
        else $error("enqueue into full queue not rejected");

    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != ST_DEQUEUED) |->
        (rsp.out_data == '0 && rsp.out_priority == '0))
        else $error("nonzero payload without dequeue");
`endif

endmodule
